>>> rtl/core/apmc_pkg.sv
package apmc_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int PEDALS = 2;
  localparam int PEDAL_BITS = 1;
  localparam int VALUE_BITS = 7;
  localparam int NUM_BITS = SAMPLE_BITS + VALUE_BITS;
  localparam int STEP_BITS = 3;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 7;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MASK = {SAMPLE_BITS{1'b1}};
  localparam logic [SAMPLE_BITS-1:0] MIN_RESET = SAMPLE_BITS'(SAMPLE_MASK / 2 - 1);
  localparam logic [SAMPLE_BITS-1:0] MAX_RESET = SAMPLE_BITS'(SAMPLE_MASK / 2 + 1);
  localparam logic [VALUE_BITS-1:0] VALUE_TOP = 7'd127;
  localparam logic [7:0] CC_STATUS = 8'hB0;
  localparam logic [STEP_BITS-1:0] STEP_FIRST = 3'd6;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_CONTROLLER_ZERO = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CONTROLLER_ONE = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_INVERT_MASK = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CHANGE_MARGIN = 3'd3;

  typedef struct packed {
    logic [PEDAL_BITS-1:0] pedal_index;
    logic [SAMPLE_BITS-1:0] raw_sample;
  } sample_word_t;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [6:0] controller_number;
    logic [6:0] controller_value;
    logic [PEDAL_BITS-1:0] source_pedal;
  } message_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALIB,
    ST_DIVIDE,
    ST_CHECK
  } ctrl_state_t;

  typedef struct packed {
    logic take;
    logic prep;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
    logic send;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/core/autocal_pedal_to_midi_cc.sv
// channel    dir  handshake                      word
// sample     in   sample_valid / sample_ready    pedal_index, raw_sample
// message    out  message_valid / message_ready  status, controller number, value, pedal
// config     in   cfg_wen                        cfg_index, cfg_data
//
// a sample is taken in the idle cycle; after the accept its message passes through:
// calibrate, seven steps of the shared restoring divider, then the margin check
// the input is ready again once the check is left, whether or not a message is sent
// a waiting message is held in the output register; the next sample is taken
// meanwhile and only stalls in its check cycle if the old message is still there
// rst is synchronous: calibration returns to 2046/2048, last values to zero
module autocal_pedal_to_midi_cc
  import apmc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      sample_valid,
  output logic                      sample_ready,
  input  sample_word_t              sample,
  output logic                      message_valid,
  input  logic                      message_ready,
  output message_word_t             message,
  input  logic                      cfg_wen,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  dp_cmd_t cmd;
  dp_status_t status;

  apmc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .status       (status),
    .cmd          (cmd)
  );

  apmc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .sample        (sample),
    .message       (message),
    .message_valid (message_valid),
    .message_ready (message_ready),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .status        (status)
  );

  assert property (@(posedge clk) disable iff (rst)
    (sample_valid && sample_ready) |=> !sample_ready)
    else $error("sample taken while one is still in work");

  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.take, cmd.prep, cmd.step, cmd.finish}))
    else $error("more than one datapath command at once");

  assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (status.send && status.out_free))
    else $error("message written without room or without change");

  assert property (@(posedge clk) disable iff (rst)
    $rose(message_valid) |-> $past(cmd.finish))
    else $error("message valid without a finished sample");

endmodule

>>> rtl/core/apmc_ctrl.sv
module apmc_ctrl
  import apmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       sample_valid,
  output logic       sample_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sample_valid) state_next = ST_CALIB;
      end
      ST_CALIB: begin
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (status.div_last) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (!status.send || status.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    sample_ready = 1'b0;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        sample_ready = 1'b1;
        cmd.take = sample_valid;
      end
      ST_CALIB: begin
        cmd.prep = 1'b1;
      end
      ST_DIVIDE: begin
        cmd.step = 1'b1;
      end
      ST_CHECK: begin
        cmd.finish = status.send && status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> rtl/core/apmc_datapath.sv
module apmc_datapath
  import apmc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  sample_word_t              sample,
  output message_word_t             message,
  output logic                      message_valid,
  input  logic                      message_ready,
  input  logic                      cfg_wen,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  dp_cmd_t                   cmd,
  output dp_status_t                status
);

  logic [6:0] controller_zero;
  logic [6:0] controller_one;
  logic [PEDALS-1:0] invert_mask;
  logic [6:0] send_margin;

  logic [SAMPLE_BITS-1:0] min_r [PEDALS];
  logic [SAMPLE_BITS-1:0] max_r [PEDALS];
  logic [VALUE_BITS-1:0] last_r [PEDALS];

  logic [PEDAL_BITS-1:0] pedal;
  logic [SAMPLE_BITS-1:0] raw;
  logic [NUM_BITS-1:0] rem;
  logic [SAMPLE_BITS-1:0] den;
  logic [VALUE_BITS-1:0] quot;
  logic [STEP_BITS-1:0] step;

  logic [SAMPLE_BITS-1:0] lo_next;
  logic [SAMPLE_BITS-1:0] hi_next;
  logic [SAMPLE_BITS-1:0] span;
  logic [NUM_BITS-1:0] num_next;
  logic [NUM_BITS-1:0] den_shift;
  logic rem_ge;
  logic [VALUE_BITS-1:0] value;
  logic [VALUE_BITS-1:0] diff;

  always_comb begin
    lo_next = (raw < min_r[pedal]) ? raw : min_r[pedal];
    hi_next = (raw > max_r[pedal]) ? raw : max_r[pedal];
    span = raw - lo_next;
    num_next = {span, {VALUE_BITS{1'b0}}} - NUM_BITS'(span);
  end

  assign den_shift = NUM_BITS'(den) << step;
  assign rem_ge = rem >= den_shift;

  assign value = (quot > VALUE_TOP) ? VALUE_TOP : quot;
  assign diff = (value > last_r[pedal]) ? value - last_r[pedal] : last_r[pedal] - value;

  assign status.div_last = (step == '0);
  assign status.send = diff > send_margin;
  assign status.out_free = !message_valid || message_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      controller_zero <= 7'd64;
      controller_one <= 7'd65;
      invert_mask <= '0;
      send_margin <= 7'd2;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_CONTROLLER_ZERO: controller_zero <= cfg_data[6:0];
        CFG_CONTROLLER_ONE: controller_one <= cfg_data[6:0];
        CFG_INVERT_MASK: invert_mask <= cfg_data[PEDALS-1:0];
        CFG_CHANGE_MARGIN: send_margin <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < PEDALS; p++) begin
        min_r[p] <= MIN_RESET;
        max_r[p] <= MAX_RESET;
        last_r[p] <= '0;
      end
    end else begin
      if (cmd.prep) begin
        min_r[pedal] <= lo_next;
        max_r[pedal] <= hi_next;
      end
      if (cmd.finish) begin
        last_r[pedal] <= value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pedal <= sample.pedal_index;
      raw <= sample.raw_sample & SAMPLE_MASK;
    end
    if (cmd.prep) begin
      rem <= num_next;
      den <= hi_next - lo_next;
      quot <= '0;
      step <= STEP_FIRST;
    end
    if (cmd.step) begin
      if (rem_ge) begin
        rem <= rem - den_shift;
        quot[step] <= 1'b1;
      end
      step <= step - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      message_valid <= 1'b0;
    end else if (cmd.finish) begin
      message_valid <= 1'b1;
    end else if (message_ready) begin
      message_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      message.status_byte <= CC_STATUS;
      message.controller_number <= (pedal == '0) ? controller_zero : controller_one;
      message.controller_value <= invert_mask[pedal] ? VALUE_TOP - value : value;
      message.source_pedal <= pedal;
    end
  end

endmodule
